### src/assert_macros.svh
// assertion macros shared by the scheduler rtl
// simulation builds get concurrent assertions, synthesis builds get nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PTRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define PTRS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define PTRS_ASSERT_IMP(label, clk, rst, ante, cons)
`define PTRS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### src/ptrs_pkg.sv
// package for the periodic task release scheduler
// request and result codes, widths and defaults; no dependencies
package ptrs_pkg;

  localparam int MAX_TASK_SLOTS_DEF = 32;
  localparam int TIME_W = 32;
  localparam int TASK_W = 5;
  localparam int MARK_W = 8;

  localparam logic [MARK_W-1:0] IDLE_MARK = 8'hFF;
  localparam logic [TIME_W-1:0] TICK_RATE_RESET = 32'd1;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_ADD    = 2'd3;

  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic                  en;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     period;
  } tbl_wr_t;

endpackage

### src/ptrs_table.sv
// task table memory: one elapsed and period pair per task slot
// one write port, one read port with registered read data; uses ptrs_pkg
module ptrs_table #(
  parameter int DEPTH = ptrs_pkg::MAX_TASK_SLOTS_DEF,
  parameter int AW = 5
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output logic [2*ptrs_pkg::TIME_W-1:0]   rd_data,
  input  ptrs_pkg::tbl_wr_t               wr,
  input  logic [AW-1:0]                   wr_addr
);
  import ptrs_pkg::*;

  logic [2*TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.elapsed, wr.period};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/periodic_task_release_scheduler_core.sv
// Periodic task release scheduler. Task periods and elapsed counts live in a
// one-port-read, one-port-write table memory; a tick walks the added tasks in
// index order (read, compare, write back), one entry per cycle while the result
// stream does not stall a release. Start, add and failed requests pass through
// the exec state; a finish that uncovers a stacked task also passes the pop-read
// state because the new stack top is fetched from the stack memory.
// Depends on ptrs_pkg, ptrs_table and assert_macros.svh.
`include "assert_macros.svh"

module periodic_task_release_scheduler_core #(
  parameter int MAX_TASK_SLOTS = ptrs_pkg::MAX_TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // task_index[4:0], period[36:5], zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // released_task[4:0], zero pad
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);
  import ptrs_pkg::*;

  localparam int IDX_W = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_TASK_SLOTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_POPRD = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state;
  logic [TIME_W-1:0]   tick_rate;
  logic [1:0]          req_r;
  logic [TASK_W-1:0]   idx_r;
  logic [TIME_W-1:0]   per_r;
  logic [CNT_W-1:0]    task_count;
  logic [CNT_W-1:0]    stack_top;
  logic [MARK_W-1:0]   top_idx;
  logic [MAX_TASK_SLOTS-1:0] running;
  logic [TASK_W-1:0]   stack_mem [MAX_TASK_SLOTS+1];
  logic [TASK_W-1:0]   stack_rd;
  logic [IDX_W-1:0]    scan_i;
  logic                pend_valid;
  logic [TASK_W-1:0]   pend_task;

  logic                m_valid;
  logic [1:0]          m_kind;
  logic [TASK_W-1:0]   m_task;
  logic                m_last;

  logic                in_beat;
  logic                slot_free;
  logic [2*TIME_W-1:0] rd_data;
  logic [TIME_W-1:0]   rd_period;
  logic [TIME_W-1:0]   rd_elapsed;
  logic                rel;
  logic                scan_last;
  logic                scan_go;
  logic                tbl_rd_en;
  logic [IDX_W-1:0]    tbl_rd_addr;
  tbl_wr_t             tbl_wr;
  logic [IDX_W-1:0]    tbl_wr_addr;
  logic                start_err;
  logic [CNT_W-1:0]    top_dec;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_valid || m_axis_tready;

  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser = m_kind;
  assign m_axis_tdata = {3'b000, m_task};
  assign m_axis_tlast = m_last;

  assign rd_period = rd_data[TIME_W-1:0];
  assign rd_elapsed = rd_data[2*TIME_W-1:TIME_W];
  assign rel = (rd_elapsed > rd_period) && (MARK_W'(scan_i) < top_idx) && !running[scan_i];
  assign scan_last = (CNT_W'(scan_i) == task_count - CNT_W'(1));
  assign scan_go = !(rel && pend_valid && !slot_free);
  assign start_err = (stack_top >= CNT_W'(MAX_TASK_SLOTS)) ||
                     ({3'b000, idx_r} >= MARK_W'(MAX_TASK_SLOTS));
  assign top_dec = stack_top - CNT_W'(1);

  always_comb begin
    tbl_rd_en = 1'b0;
    tbl_rd_addr = '0;
    tbl_wr.en = 1'b0;
    tbl_wr.elapsed = rd_elapsed + tick_rate;
    tbl_wr.period = rd_period;
    tbl_wr_addr = scan_i;
    if (state == ST_IDLE && in_beat && s_axis_tuser == REQ_TICK && task_count != '0) begin
      tbl_rd_en = 1'b1;
    end
    if (state == ST_SCAN && scan_go) begin
      tbl_wr.en = 1'b1;
      if (rel) begin
        tbl_wr.elapsed = tick_rate;
      end
      if (!scan_last) begin
        tbl_rd_en = 1'b1;
        tbl_rd_addr = scan_i + IDX_W'(1);
      end
    end
    if (state == ST_EXEC && slot_free && req_r == REQ_ADD &&
        task_count < CNT_W'(MAX_TASK_SLOTS)) begin
      tbl_wr.en = 1'b1;
      tbl_wr.elapsed = '0;
      tbl_wr.period = per_r;
      tbl_wr_addr = IDX_W'(task_count);
    end
  end

  ptrs_table #(
    .DEPTH(MAX_TASK_SLOTS),
    .AW(IDX_W)
  ) u_table (
    .clk(clk),
    .rd_en(tbl_rd_en),
    .rd_addr(tbl_rd_addr),
    .rd_data(rd_data),
    .wr(tbl_wr),
    .wr_addr(tbl_wr_addr)
  );

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && slot_free && req_r == REQ_START && !start_err) begin
      stack_mem[stack_top + CNT_W'(1)] <= idx_r;
    end
    if (state == ST_EXEC && slot_free && req_r == REQ_FINISH) begin
      stack_rd <= stack_mem[top_dec];
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_r <= s_axis_tuser;
      idx_r <= s_axis_tdata[4:0];
      per_r <= s_axis_tdata[36:5];
    end
    if (m_valid && m_axis_tready) begin
      m_valid <= 1'b0;
    end
    if (cfg_wr_en) begin
      tick_rate <= cfg_wr_data;
    end
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == REQ_TICK) begin
            scan_i <= '0;
            state <= (task_count == '0) ? ST_FIN : ST_SCAN;
          end else begin
            state <= ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          m_valid <= 1'b1;
          m_last <= 1'b1;
          m_kind <= KIND_ACK;
          m_task <= '0;
          state <= ST_IDLE;
          case (req_r)
            REQ_START: begin
              if (start_err) begin
                m_kind <= KIND_FULL;
              end else begin
                stack_top <= stack_top + CNT_W'(1);
                top_idx <= {3'b000, idx_r};
                running[IDX_W'(idx_r)] <= 1'b1;
                m_task <= idx_r;
              end
            end
            REQ_FINISH: begin
              if (stack_top == '0) begin
                m_kind <= KIND_EMPTY;
              end else begin
                m_task <= top_idx[TASK_W-1:0];
                if (top_idx < MARK_W'(MAX_TASK_SLOTS)) begin
                  running[IDX_W'(top_idx)] <= 1'b0;
                end
                stack_top <= top_dec;
                if (top_dec == '0) begin
                  top_idx <= IDLE_MARK;
                end else begin
                  state <= ST_POPRD;
                end
              end
            end
            REQ_ADD: begin
              if (task_count >= CNT_W'(MAX_TASK_SLOTS)) begin
                m_kind <= KIND_FULL;
              end else begin
                running[IDX_W'(task_count)] <= 1'b0;
                task_count <= task_count + CNT_W'(1);
                m_task <= TASK_W'(task_count);
              end
            end
            default: begin
              m_valid <= 1'b0;
            end
          endcase
        end
      end
      ST_POPRD: begin
        top_idx <= {3'b000, stack_rd};
        state <= ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_go) begin
          if (rel) begin
            if (pend_valid) begin
              m_valid <= 1'b1;
              m_kind <= KIND_RELEASE;
              m_task <= pend_task;
              m_last <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_task <= TASK_W'(scan_i);
          end
          if (scan_last) begin
            state <= ST_FIN;
          end else begin
            scan_i <= scan_i + IDX_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          m_valid <= 1'b1;
          m_last <= 1'b1;
          m_kind <= pend_valid ? KIND_RELEASE : KIND_ACK;
          m_task <= pend_valid ? pend_task : '0;
          pend_valid <= 1'b0;
          state <= ST_IDLE;
        end
      end
      default: begin
        state <= ST_IDLE;
      end
    endcase
    if (rst) begin
      state <= ST_IDLE;
      tick_rate <= TICK_RATE_RESET;
      task_count <= '0;
      stack_top <= '0;
      top_idx <= IDLE_MARK;
      running <= '0;
      pend_valid <= 1'b0;
      m_valid <= 1'b0;
    end
  end

  // bookkeeping bounds, the idle marker at the stack bottom and no pending release in idle
  `PTRS_ASSERT_IMP(a_stack_range, clk, rst, 1'b1, stack_top <= CNT_W'(MAX_TASK_SLOTS))
  `PTRS_ASSERT_IMP(a_count_range, clk, rst, 1'b1, task_count <= CNT_W'(MAX_TASK_SLOTS))
  `PTRS_ASSERT_IMP(a_idle_bottom, clk, rst, stack_top == '0, top_idx == IDLE_MARK)
  `PTRS_ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SCAN, CNT_W'(scan_i) < task_count)
  `PTRS_ASSERT_IMP(a_no_stale_pend, clk, rst, state == ST_IDLE, !pend_valid)

endmodule

### tb/sv/tb.sv
// testbench for periodic_task_release_scheduler_core: random and directed requests on the
// input stream, results checked in order against a cycle-free predictor of the task table
// depends on ptrs_pkg and the scheduler rtl
`timescale 1ns / 1ps

module tb;
  import ptrs_pkg::*;

  localparam int SLOTS = MAX_TASK_SLOTS_DEF;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] task_id;
    logic       last;
  } sched_result_t;

  class release_tracker;
    logic [TIME_W-1:0] period_tbl[SLOTS];
    logic [TIME_W-1:0] elapsed_tbl[SLOTS];
    bit                running[SLOTS];
    logic [MARK_W-1:0] run_stack[SLOTS+1];
    int unsigned       stack_ptr;
    int unsigned       task_count;
    logic [TIME_W-1:0] tick_rate;
    sched_result_t     pending_results[$];
    int unsigned       mismatches;
    int unsigned       kind_seen[4];

    function new();
      foreach (period_tbl[i]) begin
        period_tbl[i] = '0;
        elapsed_tbl[i] = '0;
        running[i] = 1'b0;
      end
      foreach (run_stack[i]) run_stack[i] = '0;
      run_stack[0] = IDLE_MARK;
      stack_ptr = 0;
      task_count = 0;
      tick_rate = TICK_RATE_RESET;
      mismatches = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endfunction

    function void accept_request(logic [1:0] req, logic [4:0] idx, logic [31:0] per);
      logic [MARK_W-1:0] top_mark;
      int unsigned       n;
      case (req)
        REQ_TICK: begin
          top_mark = run_stack[stack_ptr];
          n = 0;
          for (int i = 0; i < task_count; i++) begin
            if (elapsed_tbl[i] > period_tbl[i] && i < top_mark && !running[i]) begin
              elapsed_tbl[i] = '0;
              pending_results.push_back('{KIND_RELEASE, 5'(i), 1'b0});
              n++;
            end
            elapsed_tbl[i] = elapsed_tbl[i] + tick_rate;
          end
          if (n == 0) pending_results.push_back('{KIND_ACK, 5'd0, 1'b1});
          else pending_results[pending_results.size()-1].last = 1'b1;
        end
        REQ_START: begin
          if (stack_ptr >= SLOTS || idx >= SLOTS) begin
            pending_results.push_back('{KIND_FULL, 5'd0, 1'b1});
          end else begin
            stack_ptr++;
            run_stack[stack_ptr] = MARK_W'(idx);
            running[idx] = 1'b1;
            pending_results.push_back('{KIND_ACK, idx, 1'b1});
          end
        end
        REQ_FINISH: begin
          if (stack_ptr == 0) begin
            pending_results.push_back('{KIND_EMPTY, 5'd0, 1'b1});
          end else begin
            top_mark = run_stack[stack_ptr];
            if (top_mark < SLOTS) running[top_mark] = 1'b0;
            run_stack[stack_ptr] = IDLE_MARK;
            stack_ptr--;
            pending_results.push_back('{KIND_ACK, top_mark[4:0], 1'b1});
          end
        end
        default: begin
          if (task_count >= SLOTS) begin
            pending_results.push_back('{KIND_FULL, 5'd0, 1'b1});
          end else begin
            period_tbl[task_count] = per;
            elapsed_tbl[task_count] = '0;
            running[task_count] = 1'b0;
            pending_results.push_back('{KIND_ACK, 5'(task_count), 1'b1});
            task_count++;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [4:0] task_id, logic last);
      sched_result_t exp_r;
      kind_seen[kind]++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d task %0d last %0b",
                                kind, task_id, last));
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.kind !== kind || exp_r.task_id !== task_id || exp_r.last !== last)
          flag_mismatch($sformatf("got kind %0d task %0d last %0b, want kind %0d task %0d last %0b",
                                  kind, task_id, last, exp_r.kind, exp_r.task_id, exp_r.last));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_tdata = '0;     // task_index[4:0], period[36:5], zero pad
  logic [1:0]  s_tuser = '0;     // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_axis_tdata;     // released_task[4:0], zero pad
  logic [1:0]  m_axis_tuser;     // kind[1:0]
  logic        m_axis_tlast;

  release_tracker sb;
  bit             quiet = 1'b0;
  int             stall_left = 0;
  int unsigned    items_sent = 0;

  periodic_task_release_scheduler_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic logic [31:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom_range(0, 30);
    if (roll < 65) return $urandom;
    if (roll < 80) return 32'd0;
    if (roll < 90) return 32'hFFFF_FFFF;
    return $urandom_range(0, 1000);
  endfunction

  // result side: check accepted beats, then decide backpressure for the next edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_ready)
        sb.check_result(m_axis_tuser, m_axis_tdata[4:0], m_axis_tlast);
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_pause();
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [4:0] idx,
                              input logic [31:0] per);
    int gap;
    gap = quiet ? 0 : pick_pause();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {3'b000, per, idx};
    do @(posedge clk); while (!s_axis_tready);
    sb.accept_request(req, idx, per);
    items_sent++;
  endtask

  task automatic set_tick_rate(input logic [31:0] rate);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.tick_rate = rate;
  endtask

  task automatic run_random(input int count);
    int          roll;
    logic [1:0]  req;
    logic [4:0]  idx;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) req = REQ_TICK;
      else if (roll < 60) req = REQ_START;
      else if (roll < 80) req = REQ_FINISH;
      else req = REQ_ADD;
      idx = ($urandom_range(0, 3) == 0) ? 5'd31 : 5'($urandom);
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      send_request(req, idx, pick_period());
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table and stack, then a few tasks released under different stack tops
    send_request(REQ_TICK, 5'd0, 32'd0);
    send_request(REQ_FINISH, 5'd0, 32'd0);
    send_request(REQ_ADD, 5'd31, 32'd0);
    send_request(REQ_ADD, 5'd0, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 5'd0, 32'd2);
    send_request(REQ_TICK, 5'd0, 32'd0);
    send_request(REQ_TICK, 5'd31, 32'hFFFF_FFFF);
    send_request(REQ_START, 5'd31, 32'd0);
    send_request(REQ_START, 5'd0, 32'hFFFF_FFFF);
    send_request(REQ_TICK, 5'd0, 32'd0);
    send_request(REQ_FINISH, 5'd0, 32'd0);
    send_request(REQ_FINISH, 5'd0, 32'd0);
    send_request(REQ_FINISH, 5'd0, 32'd0);
    send_request(REQ_START, 5'd2, 32'd0);
    send_request(REQ_TICK, 5'd0, 32'd0);
    send_request(REQ_START, 5'd2, 32'd0);
    send_request(REQ_TICK, 5'd0, 32'd0);
    send_request(REQ_FINISH, 5'd0, 32'd0);
    send_request(REQ_FINISH, 5'd0, 32'd0);
    send_request(REQ_TICK, 5'd0, 32'd0);

    // largest rate wraps elapsed counts quickly, then a zero rate stops them growing
    set_tick_rate(32'hFFFF_FFFF);
    run_random(40);
    set_tick_rate(32'd0);
    run_random(40);

    // fill the stack past its depth, then drain it past empty
    quiet = 1'b1;
    repeat (34) send_request(REQ_START, 5'($urandom), 32'($urandom));
    send_request(REQ_TICK, 5'd0, 32'd0);
    repeat (35) send_request(REQ_FINISH, 5'($urandom), 32'($urandom));
    send_request(REQ_TICK, 5'd0, 32'd0);
    quiet = 1'b0;

    set_tick_rate($urandom);
    run_random(60);
    set_tick_rate(32'd3);
    run_random(90);

    s_tvalid <= 1'b0;
    for (int n = 0; n < 200000 && sb.pending_results.size() != 0; n++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending_results.size()));

    $display("sent %0d requests, final table holds %0d tasks, tick rate ended at %0d",
             items_sent, sb.task_count, sb.tick_rate);
    $display("results seen: %0d releases, %0d acks, %0d full, %0d empty",
             sb.kind_seen[KIND_RELEASE], sb.kind_seen[KIND_ACK],
             sb.kind_seen[KIND_FULL], sb.kind_seen[KIND_EMPTY]);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout waiting on the scheduler");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/ptrs_pkg.sv
src/ptrs_table.sv
src/periodic_task_release_scheduler_core.sv
tb/sv/tb.sv
